@@ hw/rtl/fbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants for the fixed-size block free-list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int WORD_BYTES = 8;
  localparam int IDX_W      = 8;   // block index width
  localparam int LINK_W     = 9;   // link / head width, MSB set means null
  localparam int CNT_W      = 9;   // free count and block count width
  localparam int BYTES_W    = 13;  // block size register width
  localparam int OFFS_W     = 21;  // byte offset width
  localparam int WC_W       = 11;  // stride in words
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [LINK_W-1:0]     LINK_NULL     = 9'd256;
  localparam logic [CNT_W-1:0]      CNT_MAX       = 9'd256;
  localparam logic [CNT_W-1:0]      BLOCKS_RESET  = 9'd256;
  localparam logic [BYTES_W-1:0]    BYTES_RESET   = 13'd8;
  localparam logic [CFG_IDX_W-1:0]  REG_BLK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_BLK_BYTES = 2'd1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INIT,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;      // capture the request
    logic exec;     // apply alloc, free or no-op and load the result
    logic init_wr;  // write one link of the init walk
    logic fin;      // finish init and load the result
  } fbfl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic last;     // init walk at its final entry
    logic n_zero;   // effective block count is zero
    logic out_free; // result register can take a new result
  } fbfl_stat_t;

endpackage

@@ hw/rtl/fbfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Sequencer for the allocator: request capture, execute, init walk, finish.
// ----------------------------------------------------------------------------
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  fbfl_stat_t stat,
  output fbfl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.op == OP_INIT) begin
          state_next = stat.n_zero ? ST_FIN : ST_INIT;
        end else if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_INIT: begin
        if (stat.last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        // hold off requests while in reset
        in_ready = ~rst;
        cmd.cap  = in_valid && ~rst;
      end
      ST_EXEC: begin
        cmd.exec = (stat.op != OP_INIT) && stat.out_free;
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
      end
      ST_FIN: begin
        cmd.fin = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/fbfl_dpath.sv @@
// ----------------------------------------------------------------------------
// fbfl_dpath
// Link memory, head pointer, free counter, config registers and result register.
// ----------------------------------------------------------------------------
module fbfl_dpath
  import fbfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  fbfl_cmd_t             cmd,
  output fbfl_stat_t            stat,
  input  logic [1:0]            op,
  input  logic [IDX_W-1:0]      block_index,
  input  logic                  null_block,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  granted,
  output logic [IDX_W-1:0]      granted_index,
  output logic [OFFS_W-1:0]     granted_offset,
  output logic                  pool_empty,
  output logic [CNT_W-1:0]      free_count
);

  logic [LINK_W-1:0]  link_mem [MAX_BLOCKS];
  logic [LINK_W-1:0]  link_rd;

  logic [CNT_W-1:0]   block_count;
  logic [BYTES_W-1:0] block_bytes;
  logic [LINK_W-1:0]  free_head;
  logic [LINK_W-1:0]  free_head_next;
  logic [CNT_W-1:0]   free_total;
  logic [CNT_W-1:0]   free_total_next;

  op_t                op_q;
  logic [IDX_W-1:0]   idx_q;
  logic               null_q;
  logic [IDX_W-1:0]   walk;

  logic [CNT_W-1:0]   eff_count;
  logic [BYTES_W:0]   bytes_up;
  logic [WC_W-1:0]    stride_words;
  logic [IDX_W+WC_W-1:0] prod;
  logic [IDX_W+WC_W-1:0] prod_p1;
  logic               head_valid;
  logic               free_ok;
  logic               wr_free;
  logic               walk_last;
  logic [LINK_W-1:0]  walk_link;

  logic               res_granted;
  logic [IDX_W-1:0]   res_index;
  logic [OFFS_W-1:0]  res_offset;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCKS_RESET;
      block_bytes <= BYTES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLK_COUNT: block_count <= cfg_data[CNT_W-1:0];
        REG_BLK_BYTES: block_bytes <= cfg_data[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_count    = (block_count > CNT_MAX) ? CNT_MAX : block_count;
  assign bytes_up     = {1'b0, block_bytes} + (BYTES_W+1)'(WORD_BYTES - 1);
  assign stride_words = bytes_up[BYTES_W:3];

  // request capture and init walk counter
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q   <= op_t'(op);
      idx_q  <= block_index;
      null_q <= null_block;
      walk   <= '0;
    end else if (cmd.init_wr) begin
      walk   <= walk + IDX_W'(1);
    end
  end

  assign walk_last = ({1'b0, walk} == eff_count - CNT_W'(1));
  assign walk_link = walk_last ? LINK_NULL : ({1'b0, walk} + LINK_W'(1));

  assign head_valid = ~free_head[LINK_W-1];
  assign free_ok    = ~null_q && ({1'b0, idx_q} < eff_count);
  assign wr_free    = cmd.exec && (op_q == OP_FREE) && free_ok;

  // link memory: one write port, one registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      link_mem[walk] <= walk_link;
    end else if (wr_free) begin
      link_mem[idx_q] <= free_head;
    end
    link_rd <= link_mem[free_head[IDX_W-1:0]];
  end

  // offset = WORD_BYTES * (1 + index * stride_words), kept to 21 bits
  assign prod    = free_head[IDX_W-1:0] * stride_words;
  assign prod_p1 = prod + (IDX_W+WC_W)'(1);

  always_comb begin
    free_head_next  = free_head;
    free_total_next = free_total;
    res_granted     = 1'b0;
    res_index       = '0;
    res_offset      = '0;
    if (cmd.fin) begin
      free_head_next  = (eff_count != '0) ? '0 : LINK_NULL;
      free_total_next = eff_count;
    end else if (cmd.exec) begin
      case (op_q)
        OP_ALLOC: begin
          if (head_valid) begin
            res_granted    = 1'b1;
            res_index      = free_head[IDX_W-1:0];
            res_offset     = {prod_p1[OFFS_W-4:0], 3'b000};
            free_head_next = link_rd;
            if (free_total != '0) free_total_next = free_total - CNT_W'(1);
          end
        end
        OP_FREE: begin
          if (free_ok) begin
            free_head_next = {1'b0, idx_q};
            if (free_total < CNT_MAX) free_total_next = free_total + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= LINK_NULL;
      free_total <= '0;
    end else begin
      free_head  <= free_head_next;
      free_total <= free_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.fin) begin
      granted        <= res_granted;
      granted_index  <= res_index;
      granted_offset <= res_offset;
      pool_empty     <= free_head_next[LINK_W-1];
      free_count     <= free_total_next;
    end
  end

  assign stat.op       = op_q;
  assign stat.last     = walk_last;
  assign stat.n_zero   = (eff_count == '0);
  assign stat.out_free = ~out_valid || out_ready;

endmodule

@@ hw/rtl/fixed_block_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of fixed-size blocks kept on a LIFO free list in a link memory.
// ----------------------------------------------------------------------------
// Allocate, free and unused codes: capture, then one read-modify-write of the
//   link memory once the result register is free; the result is registered.
// Initialize walks the link memory, writing one link per cycle, then finishes.
// A new request is taken while the previous result waits to be read.
// Synchronous reset empties the list, clears the free count and restores the
//   block count to 256 and block size to 8; link memory is not cleared.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [IDX_W-1:0]      block_index,
  input  logic                  null_block,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  granted,
  output logic [IDX_W-1:0]      granted_index,
  output logic [OFFS_W-1:0]     granted_offset,
  output logic                  pool_empty,
  output logic [CNT_W-1:0]      free_count
);

  fbfl_cmd_t  cmd;
  fbfl_stat_t stat;

  assign cfg_ready = ~rst;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbfl_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (op),
    .block_index    (block_index),
    .null_block     (null_block),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted        (granted),
    .granted_index  (granted_index),
    .granted_offset (granted_offset),
    .pool_empty     (pool_empty),
    .free_count     (free_count)
  );

endmodule

@@ sim/fbfl_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbfl_checker
// Watches the request, register and result channels of the free-list
// allocator, keeps its own copy of the list, links, counter and registers,
// and compares every result with the oldest predicted one.
// ----------------------------------------------------------------------------
module fbfl_checker
  import fbfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [IDX_W-1:0]      block_index,
  input  logic                  null_block,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  granted,
  input  logic [IDX_W-1:0]      granted_index,
  input  logic [OFFS_W-1:0]     granted_offset,
  input  logic                  pool_empty,
  input  logic [CNT_W-1:0]      free_count,
  output int                    outstanding,
  output int                    errors
);

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  index;
    logic [OFFS_W-1:0] offset;
    logic              empty;
    logic [CNT_W-1:0]  count;
  } alloc_result_t;

  logic [CNT_W-1:0]   pool_blocks;
  logic [BYTES_W-1:0] pool_bytes;
  logic [LINK_W-1:0]  list_head;
  logic [LINK_W-1:0]  list_link [MAX_BLOCKS];
  logic [CNT_W-1:0]   list_free;

  alloc_result_t pending_results[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t fbfl_chk: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // Apply one request to the list copy and return the status it reports.
  function automatic alloc_result_t alloc_step(op_t code, logic [IDX_W-1:0] idx, logic nb);
    alloc_result_t r;
    logic [CNT_W-1:0] n;
    logic [31:0] stride;
    r = '0;
    n = (pool_blocks > CNT_MAX) ? CNT_MAX : pool_blocks;
    stride = ((32'(pool_bytes) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
    case (code)
      OP_ALLOC: begin
        if (list_head < LINK_NULL) begin
          r.granted = 1'b1;
          r.index = list_head[IDX_W-1:0];
          r.offset = OFFS_W'(WORD_BYTES + 32'(list_head) * stride);
          list_head = list_link[list_head[IDX_W-1:0]];
          if (list_free != '0) list_free--;
        end
      end
      OP_FREE: begin
        if (!nb && {1'b0, idx} < n) begin
          list_link[idx] = list_head;
          list_head = {1'b0, idx};
          if (list_free < CNT_MAX) list_free++;
        end
      end
      OP_INIT: begin
        for (int i = 0; i < n; i++) begin
          list_link[i] = (i + 1 < n) ? LINK_W'(i + 1) : LINK_NULL;
        end
        list_head = (n != '0) ? '0 : LINK_NULL;
        list_free = n;
      end
      default: ;
    endcase
    r.empty = (list_head >= LINK_NULL);
    r.count = list_free;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      pool_blocks = BLOCKS_RESET;
      pool_bytes = BYTES_RESET;
      list_head = LINK_NULL;
      list_free = '0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      // Check the leaving result before queuing a new prediction.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report("result with no request pending", 0, 0);
        end else begin
          want = pending_results.pop_front();
          if (granted !== want.granted)
            report("granted", 32'(granted), 32'(want.granted));
          if (granted_index !== want.index)
            report("granted_index", 32'(granted_index), 32'(want.index));
          if (granted_offset !== want.offset)
            report("granted_offset", 32'(granted_offset), 32'(want.offset));
          if (pool_empty !== want.empty)
            report("pool_empty", 32'(pool_empty), 32'(want.empty));
          if (free_count !== want.count)
            report("free_count", 32'(free_count), 32'(want.count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLK_COUNT: pool_blocks = cfg_data[CNT_W-1:0];
          REG_BLK_BYTES: pool_bytes = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_results.push_back(alloc_step(op_t'(op), block_index, null_block));
      outstanding <= pending_results.size();
    end
  end

endmodule

@@ sim/tb_fixed_block_free_list_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator
// Drives allocate, free, initialize and unused requests through several pool
// settings, with bursty requests and a stalling result side; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            op = OP_ALLOC;
  logic [IDX_W-1:0]      block_index = '0;
  logic                  null_block = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BLK_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  granted;
  logic [IDX_W-1:0]      granted_index;
  logic [OFFS_W-1:0]     granted_offset;
  logic                  pool_empty;
  logic [CNT_W-1:0]      free_count;

  int outstanding;
  int errors;

  int burst_left = 0;
  bit req_up = 1'b0;
  int cur_count = MAX_BLOCKS;

  int rx_cyc = 0;
  int hold_left = 0;
  int rx_mode = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fixed_block_free_list_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .block_index    (block_index),
    .null_block     (null_block),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted        (granted),
    .granted_index  (granted_index),
    .granted_offset (granted_offset),
    .pool_empty     (pool_empty),
    .free_count     (free_count)
  );

  fbfl_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .block_index    (block_index),
    .null_block     (null_block),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted        (granted),
    .granted_index  (granted_index),
    .granted_offset (granted_offset),
    .pool_empty     (pool_empty),
    .free_count     (free_count),
    .outstanding    (outstanding),
    .errors         (errors)
  );

  // Result side: periodic long hold-off, otherwise one of three stall modes that
  // is re-chosen at random.
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_cyc % 2500 == 1000) begin
      out_ready <= 1'b0;
      hold_left <= 150;
    end else begin
      if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_req(input op_t code, input int idx, input logic nb);
    if (burst_left == 0) begin
      if (req_up) begin
        in_valid <= 1'b0;
        req_up = 1'b0;
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    req_up = 1'b1;
    op <= code;
    block_index <= IDX_W'(idx);
    null_block <= nb;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (which == REG_BLK_COUNT) begin
      cur_count = value & 511;
      if (cur_count > MAX_BLOCKS) cur_count = MAX_BLOCKS;
    end
  endtask

  // Drop the request line and wait until every result has come back.
  task automatic settle();
    if (req_up) begin
      in_valid <= 1'b0;
      req_up = 1'b0;
    end
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_reqs(input int n);
    int r;
    int idx;
    logic nb;
    repeat (n) begin
      r = $urandom_range(0, 99);
      idx = $urandom_range(0, 255);
      nb = 1'($urandom_range(0, 1));
      if (r < 45 || r >= 97) begin
        send_req(OP_ALLOC, idx, nb);
      end else if (r < 90) begin
        r = $urandom_range(0, 99);
        nb = 1'b0;
        if (r < 6) nb = 1'b1;
        else if (r < 12 && cur_count < MAX_BLOCKS) idx = $urandom_range(cur_count, 255);
        else if (cur_count > 0) idx = $urandom_range(0, cur_count - 1);
        send_req(OP_FREE, idx, nb);
      end else if (r < 95) begin
        send_req(OP_NOP, idx, nb);
      end else begin
        send_req(OP_INIT, idx, nb);
      end
    end
  endtask

  task automatic run_phase(input int count, input int bytes, input int n);
    settle();
    write_reg(REG_BLK_COUNT, count);
    write_reg(REG_BLK_BYTES, bytes);
    send_req(OP_INIT, 0, 1'b0);
    random_reqs(n);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list after reset, unused code, ignored null free, lone push/pop
    send_req(OP_ALLOC, 0, 1'b0);
    send_req(OP_NOP, 255, 1'b1);
    send_req(OP_FREE, 255, 1'b1);
    send_req(OP_FREE, 170, 1'b0);
    send_req(OP_ALLOC, 85, 1'b1);
    send_req(OP_ALLOC, 0, 1'b0);
    // full pool: counter saturates on an extra free, then a double free
    send_req(OP_INIT, 0, 1'b0);
    send_req(OP_FREE, 3, 1'b0);
    send_req(OP_ALLOC, 0, 1'b0);
    send_req(OP_ALLOC, 0, 1'b0);
    send_req(OP_FREE, 255, 1'b0);
    send_req(OP_FREE, 255, 1'b0);
    send_req(OP_ALLOC, 0, 1'b0);
    send_req(OP_ALLOC, 0, 1'b0);

    // saturated block count, zero block size, writes to unused indexes
    settle();
    write_reg(REG_BLK_COUNT, 300);
    write_reg(REG_BLK_BYTES, 0);
    write_reg(REG_SPARE, 8191);
    write_reg(REG_UNUSED, 5461);
    send_req(OP_INIT, 0, 1'b0);
    send_req(OP_ALLOC, 0, 1'b0);
    send_req(OP_FREE, 85, 1'b0);
    send_req(OP_ALLOC, 0, 1'b0);

    // zero block count gives an empty pool
    settle();
    write_reg(REG_BLK_COUNT, 0);
    send_req(OP_INIT, 0, 1'b0);
    send_req(OP_FREE, 0, 1'b0);
    send_req(OP_ALLOC, 0, 1'b0);

    // single block, 4096-byte size, free past the end is ignored
    settle();
    write_reg(REG_BLK_COUNT, 1);
    write_reg(REG_BLK_BYTES, 4096);
    send_req(OP_INIT, 0, 1'b0);
    send_req(OP_FREE, 1, 1'b0);
    send_req(OP_ALLOC, 0, 1'b0);

    run_phase(1, 0, 60);
    run_phase(2, 4096, 50);
    run_phase(256, 8, 80);
    run_phase(511, 8191, 70);
    run_phase(0, 13, 20);
    run_phase(17, 100, 50);
    run_phase($urandom_range(1, 256), $urandom_range(0, 8191), 50);
    run_phase($urandom_range(1, 256), $urandom_range(1, 4096), 50);
    run_phase(256, $urandom_range(1, 4096), 60);

    settle();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("fixed_block_free_list_allocator: match");
    end else begin
      $display("fixed_block_free_list_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #7_200_000;
    $display("fixed_block_free_list_allocator: mismatch");
    $finish;
  end

endmodule
